// ----- rtl/segment_table_insert_top_defines.svh -----
// Assertion macros for the segment table insert block.
// They expect clock and reset to be visible where they are used.
`ifndef SEGMENT_TABLE_INSERT_TOP_DEFINES_SVH
`define SEGMENT_TABLE_INSERT_TOP_DEFINES_SVH

// Same-cycle implication.
`define STI_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define STI_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/sti_pkg.sv -----
package sti_pkg;

   localparam int WORD_WIDTH       = 64;
   localparam int MAX_GROUP_BITS   = 8;
   localparam int WAYS             = 8;
   localparam int WAY_BITS         = $clog2(WAYS);
   localparam int INDEX_BITS       = WAY_BITS + MAX_GROUP_BITS;
   localparam int TABLE_DEPTH      = WAYS << MAX_GROUP_BITS;
   localparam int ENTRY_WIDTH      = 2 * WORD_WIDTH;
   localparam int GROUP_BITS_WIDTH = 4;
   localparam int ACTION_WIDTH     = 2;

   localparam int ONE_T_BIT  = 62;
   localparam int VALID_BIT  = 27;
   localparam int SHIFT_256M = 28;
   localparam int SHIFT_1T   = 40;

   localparam logic [ACTION_WIDTH-1:0] ACT_PRESENT = 2'd0;
   localparam logic [ACTION_WIDTH-1:0] ACT_FREE    = 2'd1;
   localparam logic [ACTION_WIDTH-1:0] ACT_CASTOUT = 2'd2;

   typedef struct packed {
      logic [WORD_WIDTH-1:0] vsid_word;
      logic [WORD_WIDTH-1:0] esid_word;
   } req_type;

   typedef struct packed {
      logic [ACTION_WIDTH-1:0] action;
      logic [INDEX_BITS-1:0]   entry_index;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_WRITE
   } state_type;

   typedef struct packed {
      logic clear;
      logic load;
      logic scan;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic scan_last;
   } stat_type;

endpackage

// ----- rtl/segment_table_insert_top.sv -----
// Result: a word taken in idle is answered on rsp_data, with rsp_strobe, after
//   its write state; rsp_strobe is registered, and the receiver cannot stall.
// Inserts: one at a time, busy high until the write; the eight ways of a group
//   are read one per cycle from the single table RAM, then drain and write states.
// Reset: synchronous; clears the cast-out pointer and group_bits, then a clearing pass
//   zeroes all 2048 table entries with busy high (csr writes are still taken).
module segment_table_insert_top (
   input  logic                                 clock,
   input  logic                                 reset,
   // insert requests
   input  logic                                 start,
   output logic                                 busy,
   input  sti_pkg::req_type                     req_data,
   // results, one strobe per insert
   output logic                                 rsp_strobe,
   output sti_pkg::rsp_type                     rsp_data,
   // group_bits register
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [sti_pkg::GROUP_BITS_WIDTH-1:0] csr_data
);

   import sti_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // The register is a plain flop: always ready for a word.
   assign csr_ready = 1'b1;

   // Sequencer: clear sweep, idle, eight-way scan, drain, write/respond.
   sti_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (busy)
   );

   // Hash, table RAM, way compare, victim choice and result register.
   sti_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .csr_wr     (csr_valid && csr_ready),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

// ----- rtl/sti_ram.sv -----
module sti_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/sti_ctrl.sv -----
module sti_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  sti_pkg::stat_type stat,
   output sti_pkg::cmd_type  cmd,
   output logic              busy
);

   import sti_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (stat.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (stat.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: state_in = ST_WRITE;
         ST_WRITE: state_in = ST_IDLE;
         default:  state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      unique case (state_ff)
         ST_CLEAR: cmd.clear = 1'b1;
         ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         ST_SCAN:  cmd.scan = 1'b1;
         ST_DRAIN: cmd = '0;
         ST_WRITE: cmd.finish = 1'b1;
         default:  cmd = '0;
      endcase
   end

endmodule

// ----- rtl/sti_datapath.sv -----
module sti_datapath (
   input  logic                                     clock,
   input  logic                                     reset,
   input  sti_pkg::req_type                         req_data,
   input  logic                                     csr_wr,
   input  logic [sti_pkg::GROUP_BITS_WIDTH-1:0]     csr_data,
   input  sti_pkg::cmd_type                         cmd,
   output sti_pkg::stat_type                        stat,
   output logic                                     rsp_strobe,
   output sti_pkg::rsp_type                         rsp_data
);

   import sti_pkg::*;

   logic [GROUP_BITS_WIDTH-1:0] group_bits_ff, group_bits_in;
   logic [GROUP_BITS_WIDTH-1:0] bits_sat;
   logic [MAX_GROUP_BITS-1:0]   gmask;
   logic [MAX_GROUP_BITS-1:0]   hash_src;

   logic [WORD_WIDTH-1:0]       vsid_ff, vsid_in;
   logic [WORD_WIDTH-1:0]       esid_ff, esid_in;
   logic [MAX_GROUP_BITS-1:0]   group_ff, group_in;
   logic [WAY_BITS-1:0]         way_cnt_ff, way_cnt_in;
   logic [WAY_BITS-1:0]         rd_way_ff, rd_way_in;
   logic                        rd_vld_ff, rd_vld_in;
   logic                        match_ff, match_in;
   logic                        free_ff, free_in;
   logic [WAY_BITS-1:0]         free_way_ff, free_way_in;
   logic [WAY_BITS-1:0]         ptr_ff, ptr_in;
   logic [INDEX_BITS-1:0]       clr_cnt_ff, clr_cnt_in;
   logic                        rsp_strobe_ff, rsp_strobe_in;
   rsp_type                     rsp_data_ff, rsp_data_in;

   logic [WAY_BITS-1:0]         target_way;
   logic                        ram_wr_en;
   logic [INDEX_BITS-1:0]       ram_wr_addr;
   logic [ENTRY_WIDTH-1:0]      ram_wr_data;
   logic [ENTRY_WIDTH-1:0]      ram_rd_data;
   logic                        hit;
   logic                        way_free;

   // group count saturates at the table size
   assign bits_sat = (group_bits_ff > GROUP_BITS_WIDTH'(MAX_GROUP_BITS)) ?
                     GROUP_BITS_WIDTH'(MAX_GROUP_BITS) : group_bits_ff;

   always_comb begin
      for (int i = 0; i < MAX_GROUP_BITS; i++) begin
         gmask[i] = (GROUP_BITS_WIDTH'(i) < bits_sat);
      end
   end

   assign hash_src = req_data.vsid_word[ONE_T_BIT] ?
                     req_data.esid_word[SHIFT_1T +: MAX_GROUP_BITS] :
                     req_data.esid_word[SHIFT_256M +: MAX_GROUP_BITS];

   // entry layout: vsid in the upper word, esid in the lower
   assign hit      = (ram_rd_data == {vsid_ff, esid_ff});
   assign way_free = !ram_rd_data[VALID_BIT];

   assign target_way = free_ff ? free_way_ff : ptr_ff;

   always_comb begin
      group_bits_in = csr_wr ? csr_data : group_bits_ff;

      vsid_in     = vsid_ff;
      esid_in     = esid_ff;
      group_in    = group_ff;
      way_cnt_in  = way_cnt_ff;
      match_in    = match_ff;
      free_in     = free_ff;
      free_way_in = free_way_ff;
      ptr_in      = ptr_ff;
      clr_cnt_in  = clr_cnt_ff;
      rd_vld_in   = cmd.scan;
      rd_way_in   = way_cnt_ff;

      if (cmd.load) begin
         vsid_in     = req_data.vsid_word;
         esid_in     = req_data.esid_word;
         group_in    = hash_src & gmask;
         way_cnt_in  = '0;
         match_in    = 1'b0;
         free_in     = 1'b0;
         free_way_in = '0;
      end

      if (cmd.scan) begin
         way_cnt_in = way_cnt_ff + 1'b1;
      end

      // one way comes back per cycle; first free way is kept
      if (rd_vld_ff) begin
         if (hit) begin
            match_in = 1'b1;
         end
         if (!free_ff && way_free) begin
            free_in     = 1'b1;
            free_way_in = rd_way_ff;
         end
      end

      if (cmd.finish && !match_ff && !free_ff) begin
         ptr_in = ptr_ff + 1'b1;
      end

      if (cmd.clear) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
      end

      rsp_strobe_in = cmd.finish;
      rsp_data_in   = rsp_data_ff;
      if (cmd.finish) begin
         if (match_ff) begin
            rsp_data_in.action      = ACT_PRESENT;
            rsp_data_in.entry_index = {group_ff, WAY_BITS'(0)};
         end else begin
            rsp_data_in.action      = free_ff ? ACT_FREE : ACT_CASTOUT;
            rsp_data_in.entry_index = {group_ff, target_way};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         group_bits_ff <= '0;
         rd_vld_ff     <= 1'b0;
         ptr_ff        <= '0;
         clr_cnt_ff    <= '0;
         rsp_strobe_ff <= 1'b0;
         way_cnt_ff    <= '0;
         match_ff      <= 1'b0;
         free_ff       <= 1'b0;
      end else begin
         group_bits_ff <= group_bits_in;
         rd_vld_ff     <= rd_vld_in;
         ptr_ff        <= ptr_in;
         clr_cnt_ff    <= clr_cnt_in;
         rsp_strobe_ff <= rsp_strobe_in;
         way_cnt_ff    <= way_cnt_in;
         match_ff      <= match_in;
         free_ff       <= free_in;
      end
   end

   always_ff @(posedge clock) begin
      vsid_ff     <= vsid_in;
      esid_ff     <= esid_in;
      group_ff    <= group_in;
      rd_way_ff   <= rd_way_in;
      free_way_ff <= free_way_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign ram_wr_en   = cmd.clear || (cmd.finish && !match_ff);
   assign ram_wr_addr = cmd.clear ? clr_cnt_ff : {group_ff, target_way};
   assign ram_wr_data = cmd.clear ? '0 : {vsid_ff, esid_ff};

   sti_ram #(
      .WIDTH (ENTRY_WIDTH),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (cmd.scan),
      .rd_addr ({group_ff, way_cnt_ff}),
      .rd_data (ram_rd_data)
   );

   assign stat.clear_last = (clr_cnt_ff == '1);
   assign stat.scan_last  = (way_cnt_ff == WAY_BITS'(WAYS - 1));

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

// ----- rtl/sti_checker.sv -----
`include "segment_table_insert_top_defines.svh"

module sti_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_strobe,
   input sti_pkg::rsp_type rsp_data
);

   import sti_pkg::*;

   logic req_accept;
   logic action_ok;
   logic present_rsp;
   logic at_base;

   assign req_accept  = start && !busy;
   assign action_ok   = (rsp_data.action == ACT_PRESENT) ||
                        (rsp_data.action == ACT_FREE) ||
                        (rsp_data.action == ACT_CASTOUT);
   assign present_rsp = rsp_strobe && (rsp_data.action == ACT_PRESENT);
   assign at_base     = (rsp_data.entry_index[WAY_BITS-1:0] == '0);

   `STI_ASSERT_NEXT(a_busy_after_accept, req_accept, busy, "not busy after accept")

   `STI_ASSERT_NEXT(a_no_early_rsp, req_accept, !rsp_strobe, "result one cycle after accept")

   `STI_ASSERT_NEXT(a_single_strobe, rsp_strobe, !rsp_strobe, "result strobed twice")

   `STI_ASSERT_NOW(a_action_code, rsp_strobe, action_ok, "bad action code")

   `STI_ASSERT_NOW(a_present_base, present_rsp, at_base, "present result not at group base")

endmodule

bind segment_table_insert_top sti_checker u_sti_checker (.*);

// ----- dv/tb_segment_table_insert_top.sv -----
`timescale 1ns / 100ps

module tb_segment_table_insert_top;
   import sti_pkg::*;

   // Settle time after the last result word.
   localparam int SETTLE_CYCLES = 16;
   // Longest quiet stretch in a good run is the clearing pass of all 2048 entries
   // after reset; each insert is otherwise bounded by its drawn gap and busy time.
   localparam int QUIET_LIMIT   = 20000;
   localparam int MAX_REPORTS   = 10;

   logic       clock     = 1'b0;
   logic       reset     = 1'b1;
   logic       start     = 1'b0;
   logic       busy;
   req_type    req_data  = '0;
   logic       rsp_strobe;
   rsp_type    rsp_data;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [GROUP_BITS_WIDTH-1:0] csr_data = '0;

   segment_table_insert_top dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // Segment table shadow: same contents, pointer and group_bits as the block
   // ---------------------------------------------------------------------
   logic [WORD_WIDTH-1:0]       shadow_vsid [TABLE_DEPTH];
   logic [WORD_WIDTH-1:0]       shadow_esid [TABLE_DEPTH];
   logic [WAY_BITS-1:0]         castout_way = '0;
   logic [GROUP_BITS_WIDTH-1:0] group_bits_q = '0;

   rsp_type     predicted_rsp_q [$];  // result words still owed by the block
   req_type     recent_words [$];     // pool of sent pairs, replayed for hits

   int unsigned fail_count    = 0;
   int unsigned insert_count  = 0;
   int unsigned present_count = 0;
   int unsigned free_count    = 0;
   int unsigned castout_count = 0;
   int unsigned csr_writes    = 0;
   int unsigned rsp_checked   = 0;
   int unsigned quiet_cycles  = 0;
   int unsigned gap_limit     = 9;    // 0 gives back-to-back requests

   initial begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         shadow_vsid[i] = '0;
         shadow_esid[i] = '0;
      end
   end

   // Insert one word into the shadow table, return the result word it yields.
   function automatic rsp_type predict_insert(input req_type w);
      rsp_type               r;
      int unsigned           gbits;
      logic [WORD_WIDTH-1:0] shifted;
      logic [WORD_WIDTH-1:0] gmask;
      int unsigned           base;
      int unsigned           e;
      int unsigned           target;
      bit                    have_free;
      gbits = (group_bits_q > MAX_GROUP_BITS) ? MAX_GROUP_BITS : group_bits_q;
      gmask = (64'd1 << gbits) - 64'd1;
      shifted = w.vsid_word[ONE_T_BIT] ? (w.esid_word >> SHIFT_1T)
                                       : (w.esid_word >> SHIFT_256M);
      base = 32'(shifted & gmask) * WAYS;
      have_free = 1'b0;
      target = 0;
      for (int way = 0; way < WAYS; way++) begin
         e = base + way;
         // any exact match wins, even with a lower way free
         if (shadow_vsid[e] == w.vsid_word && shadow_esid[e] == w.esid_word) begin
            r.action      = ACT_PRESENT;
            r.entry_index = INDEX_BITS'(base);
            present_count++;
            return r;
         end
         if (!have_free && !shadow_esid[e][VALID_BIT]) begin
            have_free = 1'b1;
            target    = e;
         end
      end
      if (have_free) begin
         r.action = ACT_FREE;
         free_count++;
      end else begin
         target      = base + castout_way;
         castout_way = castout_way + 1'b1;
         r.action    = ACT_CASTOUT;
         castout_count++;
      end
      shadow_vsid[target] = w.vsid_word;
      shadow_esid[target] = w.esid_word;
      r.entry_index = INDEX_BITS'(target);
      return r;
   endfunction

   task automatic note_failure(input string msg);
      fail_count++;
      if (fail_count <= MAX_REPORTS)
         $display("[%0t] FAIL: %s", $time, msg);
   endtask

   // ---------------------------------------------------------------------
   // Result checker: a word is taken at the edge that ends its strobe cycle
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (predicted_rsp_q.size() == 0) begin
            note_failure($sformatf("unexpected result word: action %0d index %0d",
                                   rsp_data.action, rsp_data.entry_index));
         end else begin
            want = predicted_rsp_q.pop_front();
            rsp_checked++;
            if (rsp_data.action !== want.action ||
                rsp_data.entry_index !== want.entry_index)
               note_failure($sformatf(
                  "result mismatch: expected action %0d index %0d, got action %0d index %0d",
                  want.action, want.entry_index, rsp_data.action, rsp_data.entry_index));
         end
      end
   end

   // Watchdog: any handshake on any port counts as progress.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[%0t] watchdog: no handshake for %0d cycles, %0d words owed",
                     $time, quiet_cycles, predicted_rsp_q.size());
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Drivers. Every task is entered and left in the time step of a rising edge.
   // ---------------------------------------------------------------------

   // Send one insert word. start stays high into the next call when the drawn
   // gap is zero, so it is never lowered and raised in one step.
   task automatic send_insert(input req_type w);
      int unsigned gap;
      start    <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (busy);
      predicted_rsp_q.push_back(predict_insert(w));
      insert_count++;
      gap = (gap_limit == 0) ? 0 : $urandom_range(0, gap_limit);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Wait until every owed word is back, then let the block settle.
   task automatic drain_results();
      start <= 1'b0;
      while (predicted_rsp_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // group_bits is only written with the block idle.
   task automatic write_group_bits(input logic [GROUP_BITS_WIDTH-1:0] value);
      drain_results();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      group_bits_q = value;
      csr_writes++;
   endtask

   // Random insert word. Most land in a few hot groups (low or high end of the
   // index range) so groups fill and cast out; some replay earlier pairs for
   // hits; a few are all-zero pairs or fully random noise.
   function automatic req_type random_word();
      req_type     w;
      int unsigned pick;
      logic [7:0]  grp;
      pick = $urandom_range(0, 99);
      if (pick < 30 && recent_words.size() != 0)
         return recent_words[$urandom_range(0, recent_words.size() - 1)];
      w.vsid_word = {$urandom, $urandom};
      w.esid_word = {$urandom, $urandom};
      if (pick < 33) begin
         // zero pair matches a cleared way; zero esid alone is an invalid pair
         w.esid_word = '0;
         if (pick == 30) w.vsid_word = '0;
      end else if (pick < 90) begin
         grp = ($urandom_range(0, 1) ? 8'hFC : 8'h00) | 8'($urandom_range(0, 3));
         if (w.vsid_word[ONE_T_BIT])
            w.esid_word[SHIFT_1T +: 8] = grp;
         else
            w.esid_word[SHIFT_256M +: 8] = grp;
         w.esid_word[VALID_BIT] = ($urandom_range(0, 99) < 85);
      end
      if (recent_words.size() < 48)
         recent_words.push_back(w);
      else
         recent_words[$urandom_range(0, 47)] = w;
      return w;
   endfunction

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Zero pair on a cleared table, all-ones word, invalid pair reused as free.
   task automatic test_zero_and_ones();
      write_group_bits(4'd0);
      send_insert('0);                            // already present at base 0
      send_insert('{'1, '1});                     // 1T, written to free way 0
      send_insert('{'1, '1});                     // now present
      send_insert('{64'h0, 64'h1});               // invalid pair, still written
      send_insert('{64'h1, 64'h0800_0000});       // reuses the invalid way
   endtask

   // Fill group 0, cast out round robin, then a hit beside a lower free way.
   task automatic test_fill_and_castout();
      req_type w [9];
      for (int i = 0; i < 9; i++) begin
         w[i].vsid_word = 64'(100 + i) | (64'(i & 1) << ONE_T_BIT);
         w[i].esid_word = (64'(i + 1) << 48) | (64'd1 << VALID_BIT);
         send_insert(w[i]);
      end
      // invalid pair over the cast-out way leaves that way free
      send_insert('{64'hDEAD_0000_0000_0001, 64'h0000_0003_0000_0000});
      send_insert(w[5]);                          // match wins over free way
      send_insert('{64'h7, 64'h0800_0000 | (64'd9 << 48)});   // fills free way
   endtask

   // group_bits above the maximum saturates; bits past the mask are dropped.
   task automatic test_group_bits_saturate();
      write_group_bits(4'd15);
      send_insert('{64'h0, (64'hFF << SHIFT_256M) | (64'd1 << VALID_BIT)});
      send_insert('{64'd1 << ONE_T_BIT, (64'hFF << SHIFT_1T) | (64'd1 << VALID_BIT)});
      send_insert('{64'h2, (64'h1 << (SHIFT_256M + 8)) | (64'd1 << VALID_BIT)});
      write_group_bits(4'd8);
      send_insert('{64'h3, (64'hFE << SHIFT_256M) | (64'd1 << VALID_BIT)});
   endtask

   // Random phases over several group_bits settings, idle and burst stretches.
   task automatic test_random_inserts();
      logic [GROUP_BITS_WIDTH-1:0] setting [8];
      setting = '{4'd0, 4'd1, 4'd3, 4'd15, 4'd8, 4'd2, 4'd12, 4'd5};
      setting[7] = 4'($urandom_range(0, 15));
      for (int p = 0; p < 8; p++) begin
         write_group_bits(setting[p]);
         for (int i = 0; i < 130; i++) begin
            if (i % 40 == 0) gap_limit = ($urandom_range(0, 3) == 0) ? 0 : 9;
            send_insert(random_word());
         end
      end
      gap_limit = 9;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      // table clearing pass runs with busy high
      do @(posedge clock); while (busy);

      test_zero_and_ones();
      test_fill_and_castout();
      test_group_bits_saturate();
      test_random_inserts();

      drain_results();
      if (predicted_rsp_q.size() != 0)
         note_failure($sformatf("%0d result words never arrived", predicted_rsp_q.size()));

      $display("Checked %0d of %0d inserts: %0d already present, %0d free way, %0d cast out",
               rsp_checked, insert_count, present_count, free_count, castout_count);
      $display("%0d group_bits writes incl. 0, max and saturating values; %0d failures",
               csr_writes, fail_count);
      if (fail_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/sti_pkg.sv
rtl/sti_ram.sv
rtl/sti_ctrl.sv
rtl/sti_datapath.sv
rtl/segment_table_insert_top.sv
rtl/sti_checker.sv
dv/tb_segment_table_insert_top.sv
